FILE: rtl/btl_pkg.sv
// ============================================================================
// btl_pkg
// Shared constants and the CORDIC arctangent table for the bearing turn
// limiter.
// ============================================================================
package btl_pkg;

   localparam int POS_BITS_DEF      = 32;
   localparam int ANGLE_BITS_DEF    = 16;
   localparam int CORDIC_STAGES_DEF = 16;

   localparam int TAB_LEN    = 24;
   localparam int Z_BITS     = 32;
   localparam int QUAT_GUARD = 26;
   localparam int CORDIC_W   = 64;
   localparam int STEP_BITS  = 15;
   localparam int CMD_BITS   = 16;
   localparam int QUAT_BITS  = 16;
   localparam int POS_PORT_BITS = 32;

   localparam logic [STEP_BITS-1:0] STEP_RESET = 15'd5461;

   function automatic logic [Z_BITS-1:0] atan_entry(input int idx);
      logic [Z_BITS-1:0] r;
      case (idx)
         0:  r = 32'h20000000;
         1:  r = 32'h12E4051D;
         2:  r = 32'h09FB385B;
         3:  r = 32'h051111D4;
         4:  r = 32'h028B0D43;
         5:  r = 32'h0145D7E1;
         6:  r = 32'h00A2F61E;
         7:  r = 32'h00517C55;
         8:  r = 32'h0028BE53;
         9:  r = 32'h00145F2E;
         10: r = 32'h000A2F98;
         11: r = 32'h000517CC;
         12: r = 32'h00028BE6;
         13: r = 32'h000145F3;
         14: r = 32'h0000A2F9;
         15: r = 32'h0000517C;
         16: r = 32'h000028BE;
         17: r = 32'h0000145F;
         18: r = 32'h00000A2F;
         19: r = 32'h00000517;
         20: r = 32'h0000028B;
         21: r = 32'h00000145;
         22: r = 32'h000000A2;
         23: r = 32'h00000051;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/btl_cordic.sv
// ============================================================================
// btl_cordic
// Pipelined vectoring CORDIC: one stage per iteration, angle out in binary
// angle units rounded to ANGLE_BITS. Advances when en is high.
// ============================================================================
module btl_cordic #(
   parameter int ANGLE_BITS    = btl_pkg::ANGLE_BITS_DEF,
   parameter int CORDIC_STAGES = btl_pkg::CORDIC_STAGES_DEF
) (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [btl_pkg::CORDIC_W-1:0] x_in,
   input  logic signed [btl_pkg::CORDIC_W-1:0] y_in,
   output logic        [ANGLE_BITS-1:0]        angle
);
   localparam int W  = btl_pkg::CORDIC_W;
   localparam int ZB = btl_pkg::Z_BITS;
   localparam int N  = CORDIC_STAGES;

   logic signed [W-1:0]  x_ff [N+1];
   logic signed [W-1:0]  y_ff [N+1];
   logic        [ZB-1:0] z_ff [N+1];
   logic        [ZB-1:0] z_round;

   // pre-rotation stage: fold left half plane, zero vector gives zero angle
   always_ff @(posedge clock) begin
      if (en) begin
         if (x_in < 0) begin
            x_ff[0] <= -x_in;
            y_ff[0] <= -y_in;
            z_ff[0] <= {1'b1, {(ZB-1){1'b0}}};
         end else begin
            x_ff[0] <= x_in;
            y_ff[0] <= y_in;
            z_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (en) begin
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + btl_pkg::atan_entry(i);
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - btl_pkg::atan_entry(i);
            end
         end
      end
   end

   // zero vector stays zero through every stage with z pinned by y>=0 path;
   // handle it by tracking separately
   logic zero_ff [N+1];
   always_ff @(posedge clock) begin
      if (en) zero_ff[0] <= (x_in == 0) && (y_in == 0);
   end
   for (genvar i = 0; i < N; i++) begin : g_zero
      always_ff @(posedge clock) begin
         if (en) zero_ff[i+1] <= zero_ff[i];
      end
   end

   assign z_round = z_ff[N] + (ZB'(1) << (ZB - 1 - ANGLE_BITS));
   assign angle   = zero_ff[N] ? '0 : z_round[ZB-1 -: ANGLE_BITS];

endmodule

FILE: rtl/bearing_turn_limiter.sv
// ============================================================================
// bearing_turn_limiter
// Bearing to target and yaw from quaternion, both by pipelined CORDIC; the
// heading command is the bearing clamped to yaw +/- max_turn_step.
// ============================================================================
// Usage:
//   req_ channel carries target, own position and attitude quaternion; one
//   transaction in gives one rsp_heading_cmd transaction out, in order.
//   csr_ channel writes max_turn_step (always ready); write only when idle.
//   Throughput: one transaction per cycle unless the receiver stalls.
//   Pipeline: product stage, scale stage, CORDIC pre-rotation plus CORDIC_STAGES
//   iterations, angle register, limit stage into the output reg.
//   The whole pipeline advances together; when the receiver stalls with the
//   output register full, every stage holds, so req_ready falls and nothing
//   is lost or repeated. An empty output register never holds the pipe.
//   Reset clears all valid bits and sets max_turn_step to 5461 (30 deg).
// ============================================================================
module bearing_turn_limiter #(
   parameter int POS_BITS      = btl_pkg::POS_BITS_DEF,
   parameter int ANGLE_BITS    = btl_pkg::ANGLE_BITS_DEF,
   parameter int CORDIC_STAGES = btl_pkg::CORDIC_STAGES_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [btl_pkg::POS_PORT_BITS-1:0] req_target_x,
   input  logic signed [btl_pkg::POS_PORT_BITS-1:0] req_target_y,
   input  logic signed [btl_pkg::POS_PORT_BITS-1:0] req_pos_x,
   input  logic signed [btl_pkg::POS_PORT_BITS-1:0] req_pos_y,
   input  logic signed [btl_pkg::QUAT_BITS-1:0]     req_quat_w,
   input  logic signed [btl_pkg::QUAT_BITS-1:0]     req_quat_x,
   input  logic signed [btl_pkg::QUAT_BITS-1:0]     req_quat_y,
   input  logic signed [btl_pkg::QUAT_BITS-1:0]     req_quat_z,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [btl_pkg::CMD_BITS-1:0]      rsp_heading_cmd,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic        [btl_pkg::STEP_BITS-1:0]     csr_max_turn_step
);
   localparam int W     = btl_pkg::CORDIC_W;
   localparam int PB    = btl_pkg::POS_PORT_BITS;
   localparam int DB    = POS_BITS + 1;
   localparam int GUARD = 59 - POS_BITS;
   localparam int QB    = btl_pkg::QUAT_BITS;
   localparam int AB    = ANGLE_BITS;
   localparam int CB    = btl_pkg::CMD_BITS;
   localparam int SB    = btl_pkg::STEP_BITS;
   localparam int DEPTH = CORDIC_STAGES + 5;
   localparam int PB_EXT = (POS_BITS > PB) ? POS_BITS : PB;

   logic [SB-1:0] step_ff;
   logic          adv;
   logic          valid_ff [DEPTH];

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) step_ff <= btl_pkg::STEP_RESET;
      else if (csr_valid) step_ff <= csr_max_turn_step;
   end

   assign adv       = !valid_ff[DEPTH-1] || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) valid_ff[i] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= req_valid;
         for (int i = 1; i < DEPTH; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   // stage 1: offsets and quaternion products
   logic signed [PB_EXT-1:0]  tx_e, ty_e, px_e, py_e;
   logic signed [POS_BITS-1:0] tx_t, ty_t, px_t, py_t;
   logic signed [DB-1:0]  dx_ff, dy_ff;
   logic signed [2*QB-1:0] wz_ff, xy_ff, yy_ff, zz_ff;

   assign tx_e = PB_EXT'(req_target_x);
   assign ty_e = PB_EXT'(req_target_y);
   assign px_e = PB_EXT'(req_pos_x);
   assign py_e = PB_EXT'(req_pos_y);
   assign tx_t = tx_e[POS_BITS-1:0];
   assign ty_t = ty_e[POS_BITS-1:0];
   assign px_t = px_e[POS_BITS-1:0];
   assign py_t = py_e[POS_BITS-1:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff <= DB'(tx_t) - DB'(px_t);
         dy_ff <= DB'(ty_t) - DB'(py_t);
         wz_ff <= req_quat_w * req_quat_z;
         xy_ff <= req_quat_x * req_quat_y;
         yy_ff <= req_quat_y * req_quat_y;
         zz_ff <= req_quat_z * req_quat_z;
      end
   end

   // stage 2: scale to CORDIC width
   logic signed [W-1:0] bx_ff, by_ff, qa_ff, qb_ff;
   logic signed [W-1:0] ya, yb;
   assign ya = (W'(wz_ff) + W'(xy_ff)) <<< 1;
   assign yb = (W'(64'sd1) <<< 28) - ((W'(yy_ff) + W'(zz_ff)) <<< 1);

   always_ff @(posedge clock) begin
      if (adv) begin
         bx_ff <= W'(dx_ff) <<< GUARD;
         by_ff <= W'(dy_ff) <<< GUARD;
         qa_ff <= ya <<< btl_pkg::QUAT_GUARD;
         qb_ff <= yb <<< btl_pkg::QUAT_GUARD;
      end
   end

   logic [AB-1:0] bearing, yaw;
   logic [AB-1:0] bearing_ff, yaw_ff;

   btl_cordic #(.ANGLE_BITS(AB), .CORDIC_STAGES(CORDIC_STAGES)) u_bearing (
      .clock(clock), .en(adv), .x_in(bx_ff), .y_in(by_ff), .angle(bearing));

   btl_cordic #(.ANGLE_BITS(AB), .CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
      .clock(clock), .en(adv), .x_in(qb_ff), .y_in(qa_ff), .angle(yaw));

   // rounded angles
   always_ff @(posedge clock) begin
      if (adv) begin
         bearing_ff <= bearing;
         yaw_ff     <= yaw;
      end
   end

   // limit stage
   logic [AB-1:0] lim, diff, mag, cmd;
   logic [CB-1:0] h16;
   logic [CB-1:0] cmd_ff;

   always_comb begin
      if (AB >= 16) lim = AB'(step_ff) << (AB - 16);
      else          lim = AB'(step_ff >> (16 - AB));
      diff = bearing_ff - yaw_ff;
      mag  = diff[AB-1] ? (AB'(0) - diff) : diff;
      if (diff == {1'b1, {(AB-1){1'b0}}}) mag = {1'b1, {(AB-1){1'b0}}};
      if (mag > lim) begin
         if (diff != '0 && !diff[AB-1]) cmd = yaw_ff + lim;
         else                           cmd = yaw_ff - lim;
      end else begin
         cmd = bearing_ff;
      end
      if (AB >= 16) h16 = CB'(cmd >> (AB - 16));
      else          h16 = CB'(cmd) << (16 - AB);
   end

   always_ff @(posedge clock) begin
      if (adv) cmd_ff <= h16;
   end

   assign rsp_valid       = valid_ff[DEPTH-1];
   assign rsp_heading_cmd = cmd_ff;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_heading_cmd))
      else $error("result changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("pipeline held with empty output");
   a_step_reset: assert property (@(posedge clock)
      $past(reset) |-> step_ff == btl_pkg::STEP_RESET)
      else $error("turn step not reset");

endmodule
